### src/srr_pkg.sv
// Shared widths, defaults and codes of the reorder receiver.
package srr_pkg;

  localparam int SEQ_W       = 16;
  localparam int LEN_W       = 10;
  localparam int EXP_W       = 17;
  localparam int SLOT_OUT_W  = 4;
  localparam int BYTES_W     = 17;

  localparam int WINDOW_DEF      = 8;
  localparam int BLOCK_BYTES_DEF = 512;
  localparam int QUEUE_DEPTH     = 2;

  // Reciprocal multiply for the slot number; exact for 16-bit blocks and up to 63 slots
  // after one correction step.
  localparam int RECIP_SHIFT = SEQ_W + 6;

  localparam logic [EXP_W-1:0] START_BLOCK_RST = EXP_W'(1);

  localparam logic KIND_BLOCK = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ACK
  } back_state_e;

endpackage

### src/srr_in_if.sv
// Packet descriptor channel.
interface srr_in_if;
  logic                        valid;
  logic                        ready;
  logic [srr_pkg::SEQ_W-1:0]   seq_number;
  logic [srr_pkg::LEN_W-1:0]   payload_length;

  modport source (output valid, output seq_number, output payload_length, input ready);
  modport sink   (input valid, input seq_number, input payload_length, output ready);
endinterface

### src/srr_out_if.sv
// Result channel: released blocks and acks.
interface srr_out_if;
  logic                             valid;
  logic                             ready;
  logic                             result_kind;
  logic [srr_pkg::SEQ_W-1:0]        block_id;
  logic [srr_pkg::LEN_W-1:0]        block_length;
  logic [srr_pkg::SLOT_OUT_W-1:0]   buffer_slot;
  logic                             transfer_done;
  logic                             last_result;

  modport source (output valid, output result_kind, output block_id, output block_length,
                  output buffer_slot, output transfer_done, output last_result, input ready);
  modport sink   (input valid, input result_kind, input block_id, input block_length,
                  input buffer_slot, input transfer_done, input last_result, output ready);
endinterface

### src/srr_front.sv
// Front stage: takes packet words, works out the slot number and the short-payload flag.
module srr_front #(
  parameter int WINDOW      = srr_pkg::WINDOW_DEF,
  parameter int BLOCK_BYTES = srr_pkg::BLOCK_BYTES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  srr_in_if.sink pkt_i,
  output logic push_o,
  output logic [srr_pkg::SEQ_W+srr_pkg::LEN_W+$clog2(WINDOW+1):0] push_data_o,
  input  logic push_ready_i
);

  localparam int SlotW    = $clog2(WINDOW + 1);
  localparam int NumSlots = WINDOW + 1;
  localparam int Shift    = srr_pkg::RECIP_SHIFT;
  localparam int ProdW    = srr_pkg::SEQ_W + Shift;
  localparam int QnW      = srr_pkg::SEQ_W + 6;
  localparam logic [Shift-1:0] RecipMul = Shift'((64'd1 << Shift) / NumSlots);
  localparam logic [srr_pkg::BYTES_W-1:0] BlockBytesV = srr_pkg::BYTES_W'(BLOCK_BYTES);
  localparam logic [SlotW:0] NumSlotsV = (SlotW + 1)'(NumSlots);

  logic                        sv_q, sv_d;
  logic [srr_pkg::SEQ_W-1:0]   seq_q;
  logic [srr_pkg::LEN_W-1:0]   len_q;
  logic [ProdW-1:0]            prod_q;
  logic                        accept;
  logic [srr_pkg::SEQ_W-1:0]   quot;
  logic [QnW-1:0]              qn;
  logic [QnW-1:0]              rem;
  logic [SlotW:0]              rem_lo;
  logic [SlotW:0]              slot_full;
  logic [SlotW-1:0]            slot;
  logic                        short_len;

  assign pkt_i.ready = !sv_q || push_ready_i;
  assign accept      = pkt_i.valid && pkt_i.ready;

  always_comb begin
    sv_d = sv_q;
    if (accept) begin
      sv_d = 1'b1;
    end else if (push_ready_i) begin
      sv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else begin
      sv_q <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      seq_q  <= pkt_i.seq_number;
      len_q  <= pkt_i.payload_length;
      prod_q <= ProdW'(pkt_i.seq_number) * ProdW'(RecipMul);
    end
  end

  // quotient may come out one low; one subtract fixes the remainder
  assign quot      = prod_q[ProdW-1:Shift];
  assign qn        = QnW'(quot) * QnW'(NumSlots);
  assign rem       = QnW'(seq_q) - qn;
  assign rem_lo    = rem[SlotW:0];
  assign slot_full = (rem_lo >= NumSlotsV) ? rem_lo - NumSlotsV : rem_lo;
  assign slot      = slot_full[SlotW-1:0];
  assign short_len = {{(srr_pkg::BYTES_W - srr_pkg::LEN_W){1'b0}}, len_q} < BlockBytesV;

  assign push_o      = sv_q;
  assign push_data_o = {seq_q, len_q, slot, short_len};

endmodule

### src/srr_queue.sv
// Small FIFO between the front stage and the release sequencer.
module srr_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = srr_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o,
  input  logic             pop_i
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = cnt_q != FullCnt;
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### src/srr_back.sv
// Release sequencer: window test, slot store, in-order release walk and ack.
module srr_back #(
  parameter int WINDOW = srr_pkg::WINDOW_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                      cfg_we_i,
  input  logic [srr_pkg::SEQ_W-1:0] cfg_wdata_i,
  input  logic q_valid_i,
  input  logic [srr_pkg::SEQ_W+srr_pkg::LEN_W+$clog2(WINDOW+1):0] q_data_i,
  output logic q_pop_o,
  srr_out_if.source res_o
);

  localparam int SlotW    = $clog2(WINDOW + 1);
  localparam int NumSlots = WINDOW + 1;
  localparam int CntW     = $clog2(WINDOW + 2);
  localparam int EntW     = srr_pkg::SEQ_W + srr_pkg::LEN_W + SlotW + 1;
  localparam int SEQ_W    = srr_pkg::SEQ_W;
  localparam int LEN_W    = srr_pkg::LEN_W;
  localparam int EXP_W    = srr_pkg::EXP_W;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(WINDOW);
  localparam logic [CntW-1:0]  WinCnt   = CntW'(WINDOW);

  srr_pkg::back_state_e state_q, state_d;

  logic [EXP_W-1:0]  exp_q, exp_d;
  logic [EXP_W-1:0]  cur_q, cur_d;
  logic [SlotW-1:0]  cur_slot_q, cur_slot_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              short_q, short_d;
  logic [NumSlots-1:0] valid_q;
  logic [LEN_W-1:0]  len_mem [NumSlots];

  logic [SEQ_W-1:0]  q_seq;
  logic [LEN_W-1:0]  q_len;
  logic [SlotW-1:0]  q_slot;
  logic              q_short;

  logic [EXP_W:0]    seq_x, exp_x, win_hi;
  logic              in_win, is_exp, walk_more, out_free;
  logic              set_en, clr_en, clr_all;

  logic              load;
  logic              ld_kind, ld_done;
  logic [SEQ_W-1:0]  ld_id;
  logic [LEN_W-1:0]  ld_len;
  logic [SlotW-1:0]  ld_slot;
  logic [SlotW+3:0]  ld_slot_x;

  logic              ov_q, ov_d;
  logic              o_kind_q, o_done_q;
  logic [SEQ_W-1:0]  o_id_q;
  logic [LEN_W-1:0]  o_len_q;
  logic [srr_pkg::SLOT_OUT_W-1:0] o_slot_q;

  function automatic logic [SlotW-1:0] slot_inc(input logic [SlotW-1:0] s);
    return (s == LastSlot) ? '0 : s + SlotW'(1);
  endfunction

  assign q_seq   = q_data_i[EntW-1 -: SEQ_W];
  assign q_len   = q_data_i[EntW-SEQ_W-1 -: LEN_W];
  assign q_slot  = q_data_i[SlotW:1];
  assign q_short = q_data_i[0];

  // window compare on the full expected number, no wrap
  assign seq_x     = {{(EXP_W + 1 - SEQ_W){1'b0}}, q_seq};
  assign exp_x     = {1'b0, exp_q};
  assign win_hi    = exp_x + (EXP_W + 1)'(WINDOW);
  assign in_win    = (seq_x >= exp_x) && (seq_x <= win_hi);
  assign is_exp    = seq_x == exp_x;
  assign walk_more = (cnt_q <= WinCnt) && valid_q[cur_slot_q];
  assign out_free  = !ov_q || res_o.ready;

  always_comb begin
    state_d    = state_q;
    exp_d      = exp_q;
    cur_d      = cur_q;
    cur_slot_d = cur_slot_q;
    cnt_d      = cnt_q;
    short_d    = short_q;
    q_pop_o    = 1'b0;
    set_en     = 1'b0;
    clr_en     = 1'b0;
    clr_all    = 1'b0;
    load       = 1'b0;
    ld_kind    = srr_pkg::KIND_ACK;
    ld_id      = exp_q[SEQ_W-1:0];
    ld_len     = '0;
    ld_slot    = '0;
    ld_done    = 1'b0;
    case (state_q)
      srr_pkg::ST_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          load    = 1'b1;
          if (in_win && is_exp) begin
            ld_kind    = srr_pkg::KIND_BLOCK;
            ld_id      = q_seq;
            ld_len     = q_len;
            ld_slot    = q_slot;
            cur_d      = exp_q + EXP_W'(1);
            cur_slot_d = slot_inc(q_slot);
            cnt_d      = CntW'(1);
            short_d    = q_short;
            state_d    = srr_pkg::ST_WALK;
          end else begin
            // early block is kept once; repeats and outsiders only get the ack
            set_en = in_win && !valid_q[q_slot];
          end
        end
      end
      srr_pkg::ST_WALK: begin
        if (walk_more) begin
          if (out_free) begin
            load       = 1'b1;
            ld_kind    = srr_pkg::KIND_BLOCK;
            ld_id      = cur_q[SEQ_W-1:0];
            ld_len     = len_mem[cur_slot_q];
            ld_slot    = cur_slot_q;
            clr_en     = 1'b1;
            cur_d      = cur_q + EXP_W'(1);
            cur_slot_d = slot_inc(cur_slot_q);
            cnt_d      = cnt_q + CntW'(1);
          end
        end else begin
          exp_d   = cur_q;
          clr_all = short_q;
          state_d = srr_pkg::ST_ACK;
        end
      end
      srr_pkg::ST_ACK: begin
        if (out_free) begin
          load    = 1'b1;
          ld_done = short_q;
          state_d = srr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srr_pkg::ST_IDLE;
      end
    endcase
  end

  assign ld_slot_x = {4'b0000, ld_slot};

  always_comb begin
    ov_d = ov_q;
    if (load) begin
      ov_d = 1'b1;
    end else if (res_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= srr_pkg::ST_IDLE;
      exp_q      <= srr_pkg::START_BLOCK_RST;
      cur_q      <= '0;
      cur_slot_q <= '0;
      cnt_q      <= '0;
      short_q    <= 1'b0;
      valid_q    <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      cur_slot_q <= cur_slot_d;
      cnt_q      <= cnt_d;
      short_q    <= short_d;
      ov_q       <= ov_d;
      if (cfg_we_i) begin
        exp_q   <= {1'b0, cfg_wdata_i};
        valid_q <= '0;
      end else begin
        exp_q <= exp_d;
        if (clr_all) begin
          valid_q <= '0;
        end else begin
          if (set_en) begin
            valid_q[q_slot] <= 1'b1;
          end
          if (clr_en) begin
            valid_q[cur_slot_q] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_en) begin
      len_mem[q_slot] <= q_len;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      o_kind_q <= ld_kind;
      o_id_q   <= ld_id;
      o_len_q  <= ld_len;
      o_slot_q <= ld_slot_x[3:0];
      o_done_q <= ld_done;
    end
  end

  assign res_o.valid         = ov_q;
  assign res_o.result_kind   = o_kind_q;
  assign res_o.block_id      = o_id_q;
  assign res_o.block_length  = o_len_q;
  assign res_o.buffer_slot   = o_slot_q;
  assign res_o.transfer_done = o_done_q;
  assign res_o.last_result   = o_kind_q;

endmodule

### src/sliding_window_reorder_receiver.sv
// Top level of the selective-repeat receive window.
// Takes one packet descriptor (block number, payload length) per word and returns the blocks
// that become deliverable in order, each with its length and slot, closed by an ack that
// carries the next expected block. A block ahead of the expected one but within WINDOW is held
// once; others are dropped. An in-order packet with a payload under BLOCK_BYTES ends the
// transfer and empties the store. A descriptor is registered in the front stage (slot number by
// reciprocal multiply), then the back sequencer drives one result word per cycle, unless the output
// stalls, through its single output register: a packet that is not the expected block gives one ack,
// an in-order packet that frees k held blocks goes through release, k releases, walk end check and
// ack. A two-word queue lets the front keep taking descriptors during a walk. A write of start_block
// takes effect at the next edge and empties the store; reset loads block 1.
module sliding_window_reorder_receiver #(
  parameter int WINDOW      = srr_pkg::WINDOW_DEF,
  parameter int BLOCK_BYTES = srr_pkg::BLOCK_BYTES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                      cfg_we_i,
  input  logic [srr_pkg::SEQ_W-1:0] cfg_wdata_i,
  srr_in_if.sink    pkt_i,
  srr_out_if.source res_o
);

  localparam int EntW = srr_pkg::SEQ_W + srr_pkg::LEN_W + $clog2(WINDOW + 1) + 1;

  logic            push, push_ready, q_valid, q_pop;
  logic [EntW-1:0] push_data, q_data;

  srr_front #(
    .WINDOW      (WINDOW),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pkt_i        (pkt_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  srr_queue #(
    .WIDTH (EntW),
    .DEPTH (srr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_data),
    .pop_i        (q_pop)
  );

  srr_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .res_o       (res_o)
  );

endmodule

### src/srr_checker.sv
// Port-level checks on the reorder receiver, bound to the top level.
module srr_checker #(
  parameter int WINDOW = srr_pkg::WINDOW_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_kind_i,
  input logic [srr_pkg::SEQ_W-1:0]      out_id_i,
  input logic [srr_pkg::LEN_W-1:0]      out_len_i,
  input logic [srr_pkg::SLOT_OUT_W-1:0] out_slot_i,
  input logic out_done_i,
  input logic out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_id_i) && $stable(out_kind_i))
    else $error("result word changed while stalled");

  a_ack_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == srr_pkg::KIND_ACK |->
      out_last_i && out_len_i == '0 && out_slot_i == '0)
    else $error("ack word carries block fields");

  a_block_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == srr_pkg::KIND_BLOCK |-> !out_last_i && !out_done_i)
    else $error("released block marked last or done");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == srr_pkg::KIND_BLOCK |->
      (WINDOW >= 15) || (int'(out_slot_i) <= WINDOW))
    else $error("slot number outside the window");

endmodule

bind sliding_window_reorder_receiver srr_checker #(
  .WINDOW (WINDOW)
) u_srr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_kind_i  (res_o.result_kind),
  .out_id_i    (res_o.block_id),
  .out_len_i   (res_o.block_length),
  .out_slot_i  (res_o.buffer_slot),
  .out_done_i  (res_o.transfer_done),
  .out_last_i  (res_o.last_result)
);
